[hw/rtl/pasp_pkg.sv]
package pasp_pkg;

  localparam int COORD_W          = 32;
  localparam int FACE_W           = 24;
  localparam int AXIS_W           = 2;
  localparam int TOL_W            = 16;
  localparam int CFG_DATA_W       = 32;
  localparam int CFG_IDX_W        = 2;
  localparam int MAX_VERTICES_DEF = 10;
  localparam int SIDE_CAP         = 10;
  // each edge adds at most two vertices to a side, store depth at most 31
  localparam int LEN_W            = 6;
  localparam int MAG_W            = COORD_W + 1;
  localparam int PROD_W           = 2 * MAG_W + 1;
  localparam int MDR_CNT_W        = 7;

  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_AXIS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_POS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 2'd2;

  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef logic [2:0][COORD_W-1:0] vtx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [FACE_W-1:0]         face_index;
    logic                      last_vertex;
  } in_item_t;

  typedef struct packed {
    logic                      side;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [FACE_W-1:0]         out_face;
    logic                      side_end;
    logic                      overflow;
    logic                      run_end;
  } out_item_t;

  typedef struct packed {
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
    logic [MAG_W-1:0] d;
  } mdr_op_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdr_stat_t;

  typedef struct packed {
    logic hi;
    logic lo;
  } cls_t;

  typedef enum logic [1:0] {
    MDR_IDLE,
    MDR_MUL,
    MDR_DIV
  } mdr_st_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLS_RD,
    ST_CLS_CHK,
    ST_SIDE,
    ST_EDGE_RD0,
    ST_EDGE_RD1,
    ST_EDGE_CAP,
    ST_COUNT,
    ST_EMIT_P0,
    ST_X_COORD,
    ST_X_WAIT,
    ST_EMIT_X,
    ST_NEXT
  } st_t;

  function automatic logic [COORD_W-1:0] vsel(vtx_t v, logic [AXIS_W-1:0] ax);
    logic [COORD_W-1:0] r;
    unique case (ax)
      2'd0:    r = v[0];
      2'd1:    r = v[1];
      default: r = v[2];
    endcase
    return r;
  endfunction

  function automatic cls_t classify(logic [COORD_W-1:0] c, logic [COORD_W-1:0] pos,
                                    logic [TOL_W-1:0] t);
    logic signed [COORD_W+1:0] diff;
    logic signed [COORD_W+1:0] tt;
    cls_t r;
    diff = $signed({{2{c[COORD_W-1]}}, c}) - $signed({{2{pos[COORD_W-1]}}, pos});
    tt   = $signed({{(COORD_W+2-TOL_W){1'b0}}, t});
    r.hi = diff >= tt;
    r.lo = diff <= -tt;
    return r;
  endfunction

endpackage

[hw/rtl/pasp_stream_if.sv]
interface pasp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/pasp_ram.sv]
module pasp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/pasp_mdr.sv]
module pasp_mdr (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  pasp_pkg::mdr_op_t         op,
  output pasp_pkg::mdr_stat_t       stat,
  output logic [pasp_pkg::MAG_W-1:0] q
);
  import pasp_pkg::*;

  // round(a * b / d): shift-add multiply seeded with d/2, then restoring division
  mdr_st_t              st_r, st_nxt;
  logic [PROD_W-1:0]    acc_r, acc_nxt;
  logic [PROD_W-1:0]    mc_r, mc_nxt;
  logic [MAG_W-1:0]     ml_r, ml_nxt;
  logic [MAG_W-1:0]     den_r, den_nxt;
  logic [MAG_W-1:0]     rem_r, rem_nxt;
  logic [MAG_W-1:0]     q_r, q_nxt;
  logic [MDR_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [MAG_W:0]       trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MDR_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    ml_r  <= ml_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  always_comb begin
    st_nxt   = st_r;
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    ml_nxt   = ml_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    trial    = {rem_r, acc_r[PROD_W-1]};
    unique case (st_r)
      MDR_IDLE: begin
        if (start) begin
          acc_nxt = PROD_W'(op.d >> 1);
          mc_nxt  = PROD_W'(op.a);
          ml_nxt  = op.b;
          den_nxt = op.d;
          cnt_nxt = '0;
          st_nxt  = MDR_MUL;
        end
      end
      MDR_MUL: begin
        if (ml_r[0]) begin
          acc_nxt = acc_r + mc_r;
        end
        mc_nxt  = mc_r << 1;
        ml_nxt  = ml_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MDR_CNT_W'(MAG_W - 1)) begin
          cnt_nxt = '0;
          rem_nxt = '0;
          st_nxt  = MDR_DIV;
        end
      end
      MDR_DIV: begin
        acc_nxt = acc_r << 1;
        if (trial >= {1'b0, den_r}) begin
          rem_nxt = MAG_W'(trial - {1'b0, den_r});
          q_nxt   = {q_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[MAG_W-1:0];
          q_nxt   = {q_r[MAG_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MDR_CNT_W'(PROD_W - 1)) begin
          cnt_nxt  = '0;
          done_nxt = 1'b1;
          st_nxt   = MDR_IDLE;
        end
      end
      default: st_nxt = MDR_IDLE;
    endcase
  end

  assign stat.busy = (st_r != MDR_IDLE);
  assign stat.done = done_r;
  assign q         = q_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> st_r == MDR_IDLE) else $error("mdr started while busy");
  a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(st_r) == MDR_DIV) else $error("mdr done without division");
endmodule

[hw/rtl/polygon_axis_plane_splitter_unit.sv]
// vertex load: one beat per cycle while in ST_LOAD, no result until the beat marked last_vertex
// after the last vertex: classify each stored vertex, count the side lengths when the
// polygon straddles the band, then per side read and emit each edge if the side is not empty
// each intersection runs the multiply-divide unit once per off-axis coordinate, stalls add more
// rst_n (synchronous, active low) clears control, count, face and config registers;
// the vertex store is not cleared
module polygon_axis_plane_splitter_unit #(
  parameter int MAX_VERTICES = pasp_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pasp_stream_if.sink                       in_vtx,
  pasp_stream_if.source                     out_res,
  input  logic                              cfg_we,
  input  logic [pasp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pasp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pasp_pkg::*;

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  st_t                 st_r, st_nxt;
  logic [AXIS_W-1:0]   axis_r;
  logic [COORD_W-1:0]  pos_r;
  logic [TOL_W-1:0]    tol_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [FACE_W-1:0]   face_r, face_nxt;
  logic                anyhi_r, anyhi_nxt, anylo_r, anylo_nxt;
  logic                triv_r, triv_nxt, dst_r, dst_nxt;
  logic                counting_r, counting_nxt;
  logic                side_r, side_nxt;
  logic [LEN_W-1:0]    len0_r, len0_nxt, len1_r, len1_nxt, e_r, e_nxt;
  logic [1:0]          d_r, d_nxt;
  vtx_t                p0_r, p0_nxt, p1_r, p1_nxt, x_r, x_nxt;
  out_item_t           out_r, out_nxt;
  logic                ov_r, ov_nxt;

  logic [AXIS_W-1:0]   ae;
  logic [TOL_W-1:0]    t_eff;
  logic                we;
  logic [AW-1:0]       raddr;
  logic [CNT_W-1:0]    k1;
  vtx_t                rdata, wvtx;
  cls_t                cr, c0, c1;
  logic                case_a, case_b, em_p0, em_x, last_k, slot_free, out_load;
  logic [LEN_W-1:0]    len_s, cap_len;
  logic                full;
  vtx_t                emit_v;
  logic                mdr_start;
  mdr_op_t             mdr_op;
  mdr_stat_t           mdr_stat;
  logic [MAG_W-1:0]    mdr_q;
  logic [COORD_W-1:0]  c0v, c1v;
  logic signed [MAG_W-1:0] c0s, c1s, poss, num_s, den_s, dp_s;
  logic [COORD_W-1:0]  xq;

  assign ae    = (axis_r > AXIS_Z) ? AXIS_Z : axis_r;
  assign t_eff = (tol_r == '0) ? TOL_W'(1) : tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= '0;
      pos_r  <= '0;
      tol_r  <= TOL_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPLIT_AXIS: axis_r <= cfg_data[AXIS_W-1:0];
        REG_SPLIT_POS:  pos_r  <= cfg_data[COORD_W-1:0];
        REG_TOLERANCE:  tol_r  <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign wvtx = {in_vtx.data.coord_z, in_vtx.data.coord_y, in_vtx.data.coord_x};
  assign we   = in_vtx.valid && in_vtx.ready && (cnt_r < CNT_W'(MAX_VERTICES));

  pasp_ram #(.WIDTH(3 * COORD_W), .DEPTH(MAX_VERTICES)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (wvtx),
    .raddr (raddr),
    .rdata (rdata)
  );

  // crossing operands: num = |pos - c1|, den = |c0 - c1|, mag = |p0[d] - p1[d]|
  always_comb begin
    c0v   = vsel(p0_r, ae);
    c1v   = vsel(p1_r, ae);
    c0s   = $signed({c0v[COORD_W-1], c0v});
    c1s   = $signed({c1v[COORD_W-1], c1v});
    poss  = $signed({pos_r[COORD_W-1], pos_r});
    num_s = poss - c1s;
    den_s = c0s - c1s;
    dp_s  = $signed({p0_r[d_r][COORD_W-1], p0_r[d_r]}) -
            $signed({p1_r[d_r][COORD_W-1], p1_r[d_r]});
    mdr_op.a = dp_s[MAG_W-1] ? MAG_W'(-dp_s) : MAG_W'(dp_s);
    mdr_op.b = num_s[MAG_W-1] ? MAG_W'(-num_s) : MAG_W'(num_s);
    mdr_op.d = den_s[MAG_W-1] ? MAG_W'(-den_s) : MAG_W'(den_s);
    xq = dp_s[MAG_W-1] ? p1_r[d_r] - mdr_q[COORD_W-1:0] : p1_r[d_r] + mdr_q[COORD_W-1:0];
  end

  pasp_mdr u_mdr (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mdr_start),
    .op    (mdr_op),
    .stat  (mdr_stat),
    .q     (mdr_q)
  );

  always_comb begin
    cr     = classify(vsel(rdata, ae), pos_r, t_eff);
    c0     = classify(vsel(p0_r, ae), pos_r, t_eff);
    c1     = classify(vsel(p1_r, ae), pos_r, t_eff);
    case_a = c0.lo && c1.hi;
    case_b = c0.hi && c1.lo;
    if (triv_r) begin
      em_p0 = (side_r == dst_r);
      em_x  = 1'b0;
    end else begin
      priority if (case_a) em_p0 = !side_r;
      else if (case_b)     em_p0 = side_r;
      else                 em_p0 = side_r ? !c0.lo : !c0.hi;
      em_x = case_a || case_b;
    end
    k1        = (k_r + 1'b1 == n_r) ? '0 : CNT_W'(k_r + 1'b1);
    last_k    = (k_r + 1'b1 == n_r);
    len_s     = side_r ? len1_r : len0_r;
    cap_len   = (len_s > LEN_W'(SIDE_CAP)) ? LEN_W'(SIDE_CAP) : len_s;
    full      = (e_r >= LEN_W'(SIDE_CAP));
    slot_free = !ov_r || out_res.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_LOAD;
      cnt_r      <= '0;
      face_r     <= '0;
      ov_r       <= 1'b0;
      counting_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      cnt_r      <= cnt_nxt;
      face_r     <= face_nxt;
      ov_r       <= ov_nxt;
      counting_r <= counting_nxt;
    end
    n_r     <= n_nxt;
    k_r     <= k_nxt;
    anyhi_r <= anyhi_nxt;
    anylo_r <= anylo_nxt;
    triv_r  <= triv_nxt;
    dst_r   <= dst_nxt;
    side_r  <= side_nxt;
    len0_r  <= len0_nxt;
    len1_r  <= len1_nxt;
    e_r     <= e_nxt;
    d_r     <= d_nxt;
    p0_r    <= p0_nxt;
    p1_r    <= p1_nxt;
    x_r     <= x_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    st_nxt       = st_r;
    cnt_nxt      = cnt_r;
    n_nxt        = n_r;
    k_nxt        = k_r;
    face_nxt     = face_r;
    anyhi_nxt    = anyhi_r;
    anylo_nxt    = anylo_r;
    triv_nxt     = triv_r;
    dst_nxt      = dst_r;
    counting_nxt = counting_r;
    side_nxt     = side_r;
    len0_nxt     = len0_r;
    len1_nxt     = len1_r;
    e_nxt        = e_r;
    d_nxt        = d_r;
    p0_nxt       = p0_r;
    p1_nxt       = p1_r;
    x_nxt        = x_r;
    out_nxt      = out_r;
    raddr        = k_r[AW-1:0];
    mdr_start    = 1'b0;
    out_load     = 1'b0;
    emit_v       = p0_r;
    in_vtx.ready = 1'b0;

    unique case (st_r)
      ST_LOAD: begin
        in_vtx.ready = 1'b1;
        if (in_vtx.valid) begin
          if (cnt_r == '0) begin
            face_nxt = in_vtx.data.face_index;
          end
          if (we) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (in_vtx.data.last_vertex) begin
            n_nxt     = we ? CNT_W'(cnt_r + 1'b1) : cnt_r;
            cnt_nxt   = '0;
            k_nxt     = '0;
            anyhi_nxt = 1'b0;
            anylo_nxt = 1'b0;
            st_nxt    = ST_CLS_RD;
          end
        end
      end
      ST_CLS_RD: st_nxt = ST_CLS_CHK;
      ST_CLS_CHK: begin
        anyhi_nxt = anyhi_r || cr.hi;
        anylo_nxt = anylo_r || cr.lo;
        if (last_k) begin
          k_nxt    = '0;
          side_nxt = 1'b0;
          triv_nxt = !(anyhi_nxt && anylo_nxt);
          dst_nxt  = anyhi_nxt;
          if (!(anyhi_nxt && anylo_nxt)) begin
            len0_nxt = anyhi_nxt ? '0 : LEN_W'(n_r);
            len1_nxt = anyhi_nxt ? LEN_W'(n_r) : '0;
            st_nxt   = ST_SIDE;
          end else begin
            len0_nxt     = '0;
            len1_nxt     = '0;
            counting_nxt = 1'b1;
            st_nxt       = ST_EDGE_RD0;
          end
        end else begin
          k_nxt  = k_r + 1'b1;
          st_nxt = ST_CLS_RD;
        end
      end
      ST_SIDE: begin
        e_nxt = '0;
        k_nxt = '0;
        if (len_s == '0) begin
          if (side_r) begin
            st_nxt = ST_LOAD;
          end else begin
            side_nxt = 1'b1;
          end
        end else begin
          st_nxt = ST_EDGE_RD0;
        end
      end
      ST_EDGE_RD0: st_nxt = ST_EDGE_RD1;
      ST_EDGE_RD1: begin
        raddr  = k1[AW-1:0];
        p0_nxt = rdata;
        st_nxt = ST_EDGE_CAP;
      end
      ST_EDGE_CAP: begin
        p1_nxt = rdata;
        st_nxt = counting_r ? ST_COUNT : ST_EMIT_P0;
      end
      ST_COUNT: begin
        priority if (case_a) begin
          len0_nxt = len0_r + LEN_W'(2);
          len1_nxt = len1_r + LEN_W'(1);
        end else if (case_b) begin
          len0_nxt = len0_r + LEN_W'(1);
          len1_nxt = len1_r + LEN_W'(2);
        end else begin
          len0_nxt = len0_r + LEN_W'(!c0.hi);
          len1_nxt = len1_r + LEN_W'(!c0.lo);
        end
        if (last_k) begin
          counting_nxt = 1'b0;
          side_nxt     = 1'b0;
          st_nxt       = ST_SIDE;
        end else begin
          k_nxt  = k_r + 1'b1;
          st_nxt = ST_EDGE_RD0;
        end
      end
      ST_EMIT_P0: begin
        if (!em_p0 || full || slot_free) begin
          if (em_p0) begin
            out_load = !full;
            e_nxt    = e_r + 1'b1;
          end
          d_nxt  = '0;
          st_nxt = em_x ? ST_X_COORD : ST_NEXT;
        end
      end
      ST_X_COORD: begin
        if (full) begin
          e_nxt  = e_r + 1'b1;
          st_nxt = ST_NEXT;
        end else if (d_r == ae) begin
          x_nxt[d_r] = pos_r;
          d_nxt      = d_r + 1'b1;
          if (d_r == 2'd2) begin
            st_nxt = ST_EMIT_X;
          end
        end else begin
          mdr_start = 1'b1;
          st_nxt    = ST_X_WAIT;
        end
      end
      ST_X_WAIT: begin
        if (mdr_stat.done) begin
          x_nxt[d_r] = xq;
          d_nxt      = d_r + 1'b1;
          st_nxt     = (d_r == 2'd2) ? ST_EMIT_X : ST_X_COORD;
        end
      end
      ST_EMIT_X: begin
        emit_v = x_r;
        if (slot_free) begin
          out_load = 1'b1;
          e_nxt    = e_r + 1'b1;
          st_nxt   = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (last_k) begin
          if (side_r) begin
            st_nxt = ST_LOAD;
          end else begin
            side_nxt = 1'b1;
            st_nxt   = ST_SIDE;
          end
        end else begin
          k_nxt  = k_r + 1'b1;
          st_nxt = ST_EDGE_RD0;
        end
      end
      default: st_nxt = ST_LOAD;
    endcase

    ov_nxt = ov_r && !out_res.ready;
    if (out_load) begin
      ov_nxt            = 1'b1;
      out_nxt.side      = side_r;
      out_nxt.out_x     = emit_v[0];
      out_nxt.out_y     = emit_v[1];
      out_nxt.out_z     = emit_v[2];
      out_nxt.out_face  = face_r;
      out_nxt.side_end  = (LEN_W'(e_r + 1'b1) == cap_len);
      out_nxt.overflow  = (len_s > LEN_W'(SIDE_CAP));
      out_nxt.run_end   = (LEN_W'(e_r + 1'b1) == cap_len) && (side_r || len1_r == '0);
    end
  end

  assign out_res.valid = ov_r;
  assign out_res.data  = out_r;

  a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> slot_free) else $error("result overwritten before taken");
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> e_r < LEN_W'(SIDE_CAP)) else $error("side capacity exceeded");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_VERTICES)) else $error("vertex count beyond store");
  a_mdr_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_X_WAIT && !mdr_stat.done) |-> mdr_stat.busy || $past(mdr_start))
    else $error("waiting on idle divider");
endmodule

[tb/sv/tb_polygon_axis_plane_splitter_unit.sv]
`timescale 1ns / 1ps

module tb_polygon_axis_plane_splitter_unit;
  import pasp_pkg::*;

  localparam int STORE_N = MAX_VERTICES_DEF;

  class split_scoreboard;
    logic [AXIS_W-1:0]    axis_q;
    longint               plane_q;
    longint               tol_q;
    longint               vstore[STORE_N][3];
    int                   vcount;
    logic [FACE_W-1:0]    face_q;
    longint               side_buf[2][SIDE_CAP][3];
    int                   side_n[2];
    bit                   side_ovf[2];
    out_item_t            pending_vertices[$];
    int                   errors;

    function new();
      axis_q = 0; plane_q = 0; tol_q = 1; vcount = 0; face_q = '0; errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SPLIT_AXIS: axis_q = val[AXIS_W-1:0];
        REG_SPLIT_POS:  plane_q = longint'($signed(val));
        REG_TOLERANCE:  tol_q = longint'(val[TOL_W-1:0]);
        default: ;
      endcase
    endfunction

    function void push(int s, longint v[3]);
      if (side_n[s] < SIDE_CAP) begin
        side_buf[s][side_n[s]] = v;
        side_n[s]++;
      end else begin
        side_ovf[s] = 1;
      end
    endfunction

    // exact a*b/d rounded half up on magnitudes
    function longint scale_round(longint a, longint b, longint d);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b} + {64'd0, d >> 1};
      return longint'(p / {64'd0, d});
    endfunction

    function void cross_at(int ax, longint p0[3], longint p1[3], output longint x[3]);
      longint num, den, dp, mag, q;
      num = (plane_q >= p1[ax]) ? plane_q - p1[ax] : p1[ax] - plane_q;
      den = (p0[ax] >= p1[ax]) ? p0[ax] - p1[ax] : p1[ax] - p0[ax];
      for (int d = 0; d < 3; d++) begin
        if (d == ax) begin
          x[d] = plane_q;
        end else begin
          dp = p0[d] - p1[d];
          mag = (dp >= 0) ? dp : -dp;
          q = scale_round(mag, num, den);
          x[d] = (dp >= 0) ? p1[d] + q : p1[d] - q;
        end
      end
    endfunction

    function void note_vertex(in_item_t v);
      int ax, n, npos, nneg, total, r, k1;
      longint t, up, dn, c0, c1;
      longint xp[3];
      out_item_t o;
      if (vcount == 0) face_q = v.face_index;
      if (vcount < STORE_N) begin
        vstore[vcount][0] = longint'(v.coord_x);
        vstore[vcount][1] = longint'(v.coord_y);
        vstore[vcount][2] = longint'(v.coord_z);
        vcount++;
      end
      if (!v.last_vertex) return;
      ax = (axis_q > 2) ? 2 : axis_q;
      t = (tol_q == 0) ? 1 : tol_q;
      up = plane_q + t;
      dn = plane_q - t;
      n = vcount;
      vcount = 0;
      side_n[0] = 0; side_n[1] = 0; side_ovf[0] = 0; side_ovf[1] = 0;
      npos = 0; nneg = 0;
      for (int k = 0; k < n; k++) begin
        if (vstore[k][ax] >= up) npos++;
        if (vstore[k][ax] <= dn) nneg++;
      end
      if (npos == 0 || nneg == 0) begin
        for (int k = 0; k < n; k++) push((npos == 0) ? 0 : 1, vstore[k]);
      end else begin
        for (int k = 0; k < n; k++) begin
          k1 = (k + 1 < n) ? k + 1 : 0;
          c0 = vstore[k][ax];
          c1 = vstore[k1][ax];
          if (c0 <= dn && c1 >= up) begin
            cross_at(ax, vstore[k], vstore[k1], xp);
            push(0, vstore[k]); push(0, xp); push(1, xp);
          end else if (c0 >= up && c1 <= dn) begin
            cross_at(ax, vstore[k], vstore[k1], xp);
            push(1, vstore[k]); push(1, xp); push(0, xp);
          end else begin
            if (c0 > dn) push(1, vstore[k]);
            if (c0 < up) push(0, vstore[k]);
          end
        end
      end
      total = side_n[0] + side_n[1];
      r = 0;
      for (int s = 0; s < 2; s++) begin
        for (int k = 0; k < side_n[s]; k++) begin
          o.side = s[0];
          o.out_x = side_buf[s][k][0][31:0];
          o.out_y = side_buf[s][k][1][31:0];
          o.out_z = side_buf[s][k][2][31:0];
          o.out_face = face_q;
          o.side_end = (k + 1 == side_n[s]);
          o.overflow = side_ovf[s];
          o.run_end = (r + 1 == total);
          pending_vertices = {pending_vertices, o};
          r++;
        end
      end
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t w;
      if (pending_vertices.size() == 0) begin
        report_mismatch("unexpected beat", 64'(got.out_x), 64'd0);
        return;
      end
      w = pending_vertices.pop_front();
      if (got.side !== w.side) report_mismatch("side", got.side, w.side);
      if (got.out_x !== w.out_x) report_mismatch("out_x", got.out_x, w.out_x);
      if (got.out_y !== w.out_y) report_mismatch("out_y", got.out_y, w.out_y);
      if (got.out_z !== w.out_z) report_mismatch("out_z", got.out_z, w.out_z);
      if (got.out_face !== w.out_face) report_mismatch("out_face", got.out_face, w.out_face);
      if (got.side_end !== w.side_end) report_mismatch("side_end", got.side_end, w.side_end);
      if (got.overflow !== w.overflow) report_mismatch("overflow", got.overflow, w.overflow);
      if (got.run_end !== w.run_end) report_mismatch("run_end", got.run_end, w.run_end);
    endtask
  endclass

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  bit                    burst = 0;

  pasp_stream_if #(.payload_t(in_item_t))  in_if();
  pasp_stream_if #(.payload_t(out_item_t)) out_if();

  split_scoreboard sb = new();

  polygon_axis_plane_splitter_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_vtx(in_if.sink), .out_res(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    in_if.valid = 0;
    in_if.data = '0;
    out_if.ready = 0;
  end

  initial begin
    #(30_000_000);
    $display("FAIL");
    $finish;
  end

  // result side: random stall per beat, with stall-free stretches
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = burst ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_if.ready <= 0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
      sb.check_result(out_if.data);
    end
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
  endtask

  task wait_idle();
    while (sb.pending_vertices.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // valid may drop for a random gap before each beat (none in burst mode) and drops after the last beat
  task send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                   logic [FACE_W-1:0] f, bit last);
    int gap;
    in_item_t v;
    gap = burst ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    v.coord_x = x; v.coord_y = y; v.coord_z = z; v.face_index = f; v.last_vertex = last;
    in_if.valid <= 1;
    in_if.data <= v;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    sb.note_vertex(v);
    if (last) begin
      @(negedge clk);
      in_if.valid <= 0;
    end
  endtask

  // axis coordinate: 0 below band, 1 above, 2 inside band or on its edge, 3 anywhere
  function logic [31:0] axis_coord(int kind);
    longint t, off;
    t = (sb.tol_q == 0) ? 1 : sb.tol_q;
    case (kind)
      0: off = -t - longint'($urandom_range(0, 1 << 20));
      1: off = t + longint'($urandom_range(0, 1 << 20));
      2: off = longint'($urandom_range(0, 2 * t)) - t;
      default: return $urandom;
    endcase
    return 32'(sb.plane_q + off);
  endfunction

  function logic [31:0] free_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  task send_polygon(int n, int pattern);
    logic [31:0] c[3];
    logic [FACE_W-1:0] f;
    int ax, kind;
    ax = (sb.axis_q > 2) ? 2 : sb.axis_q;
    f = FACE_W'($urandom);
    for (int i = 0; i < n; i++) begin
      c[0] = free_coord(); c[1] = free_coord(); c[2] = free_coord();
      case (pattern)
        0: kind = i % 2;
        1: kind = $urandom_range(0, 2);
        2: kind = 3;
        default: kind = $urandom_range(0, 1) ? 0 : 2;
      endcase
      c[ax] = axis_coord(kind);
      send_vertex(c[0], c[1], c[2], $urandom_range(0, 3) == 0 ? FACE_W'($urandom) : f,
                  i == n - 1);
    end
  endtask

  initial begin
    int left, n;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: reset config
    send_vertex(32'h80000000, 32'h7fffffff, 32'h0, 24'hffffff, 1);
    send_vertex(-32'sd5 <<< 16, 0, 0, 24'h000001, 0);
    send_vertex(-32'sd3 <<< 16, 1, 2, 24'h000002, 0);
    send_vertex(-32'sd1, 3, 4, 24'h000003, 1);
    send_vertex(32'sd2 <<< 16, 10, 20, 24'h0abcde, 0);
    send_vertex(-32'sd2 <<< 16, 30, 40, 24'h0abcde, 0);
    send_vertex(32'sd0, 50, 60, 24'h0abcde, 0);
    send_vertex(32'sd7 <<< 16, 70, 80, 24'h0abcde, 1);
    wait_idle();
    write_reg(REG_TOLERANCE, 32'd0);
    send_polygon(10, 0);
    send_polygon(3, 1);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(REG_SPLIT_AXIS, 1); write_reg(REG_SPLIT_POS, $urandom);
                 write_reg(REG_TOLERANCE, 32'h0000ffff); end
        1: begin write_reg(REG_SPLIT_AXIS, 2); write_reg(REG_SPLIT_POS, 32'h7fffffff);
                 write_reg(REG_TOLERANCE, 1); end
        2: begin write_reg(REG_SPLIT_AXIS, 3); write_reg(REG_SPLIT_POS, 32'h80000000);
                 write_reg(REG_TOLERANCE, $urandom_range(0, 65535)); end
        3: begin write_reg(REG_SPLIT_AXIS, 0); write_reg(REG_SPLIT_POS, 32'd0);
                 write_reg(REG_TOLERANCE, 0); end
        default: begin write_reg(REG_SPLIT_AXIS, $urandom_range(0, 3));
                 write_reg(REG_SPLIT_POS, $urandom);
                 write_reg(REG_TOLERANCE, $urandom_range(0, 65535)); end
      endcase
      left = 58;
      while (left > 0) begin
        burst = ($urandom_range(0, 5) == 0);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 13) : $urandom_range(1, 10);
        send_polygon(n, $urandom_range(0, 9) < 7 ? $urandom_range(0, 1) + 1 - 1 +
                     $urandom_range(0, 1) * 2 : $urandom_range(0, 3));
        left -= n;
      end
      burst = 0;
      wait_idle();
    end

    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending_vertices.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
